// ----- rtl/gated_velocity_estimator_defines.svh -----
// Assertion macros for the gated velocity estimator.
`ifndef GATED_VELOCITY_ESTIMATOR_DEFINES_SVH
`define GATED_VELOCITY_ESTIMATOR_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define GVE_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define GVE_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define GVE_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gve_pkg.sv -----
// Shared types and constants of the gated velocity estimator.
`default_nettype none

package gve_pkg;

    localparam int GVE_MAX_WINDOW = 32;

    localparam logic [5:0]  INTERVAL_RST = 6'd8;
    localparam logic [15:0] SCALE_RST    = 16'd8192;

    // Register index codes, taken from paddr[2]
    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_SCALE    = 1'b1;

    // -100.0 in Q8.8
    localparam logic [15:0] POS_INVALID = 16'h9C00;

    // Gate: 25*d^2 < (512*len*gap)^2
    localparam int GATE_NUM  = 25;
    localparam int LIM_SHIFT = 18;

    // Speed limits in Q8.16
    localparam logic [23:0] SPD_MAX = 24'h7FFFFF;
    localparam logic [23:0] SPD_MIN = 24'h800000;
    localparam int          SPD_MAG_LIM = 8388608;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ----- rtl/gve_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none

module gve_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/gve_div.sv -----
// Unsigned restoring divider, two quotient bits per cycle.
`default_nettype none

module gve_div
    import gve_pkg::*;
#(
    parameter int DN = 38,
    parameter int DD = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DN-1:0] dividend,
    input  wire logic [DD-1:0] divisor,
    output logic      [DN-1:0] quotient,
    output div_status_t        status
);

    localparam int STEPS = (DN + 1) / 2;
    localparam int PN    = 2 * STEPS;
    localparam int CNTW  = $clog2(STEPS + 1);

    logic [DD:0]     rem_reg;
    logic [PN-1:0]   quo_reg;
    logic [DD-1:0]   dsr_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [DD:0]     rem_next;
    logic [PN-1:0]   quo_next;

    // Two shift-subtract steps
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            rem_next = {rem_next[DD-1:0], quo_next[PN-1]};
            quo_next = {quo_next[PN-2:0], 1'b0};
            if (rem_next >= {1'b0, dsr_reg})
            begin
                rem_next    = rem_next - {1'b0, dsr_reg};
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= PN'(dividend);
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient    = quo_reg[DN-1:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/gated_velocity_estimator.sv -----
// Gated velocity estimator: sample window in RAM, sequential pair walk, scaled speed.
// Throughput: one item at a time; the pair walk through the window RAM and the
//   shared divider set the rate. A finished result waits in the output register.
// Reset: window empty, write pointer 0, interval 8, speed_scale 8192; RAM not cleared.
`default_nettype none
`include "gated_velocity_estimator_defines.svh"

module gated_velocity_estimator
    import gve_pkg::*;
#(
    parameter int MAX_WINDOW = GVE_MAX_WINDOW
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // pos_x [15:0], pos_y [31:16]
    input  wire logic [0:0]  s_tuser,   // sample_valid [0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [79:0] m_tdata,   // out_x [15:0], out_y [31:16],
                                        // speed_x [55:32], speed_y [79:56]
    output logic      [0:0]  m_tuser,   // position_ok [0]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int LW   = (CW > 6) ? CW : 6;
    localparam int PW   = AW + 17;            // k * d, signed
    localparam int TMW  = AW + 33;            // term magnitude
    localparam int SMW  = 2 * AW + 33;        // sum magnitude
    localparam int SW   = SMW + 1;            // signed sum
    localparam int WW   = 2 * AW;             // weight
    localparam int H    = (SMW + 1) / 2;      // low half of the sum for scaling
    localparam int HI   = SMW - H;
    localparam int PRW  = SMW + 16;
    localparam int FDW  = PRW - 24;
    localparam int DN   = (TMW > FDW) ? TMW : FDW;
    localparam int DD   = WW;
    localparam int LGW  = CW + AW;
    localparam int CMPW = (2 * LGW + LIM_SHIFT > 38) ? 2 * LGW + LIM_SHIFT : 38;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_GATE = 4'd4;
    localparam logic [3:0] S_DX   = 4'd5;
    localparam logic [3:0] S_DY   = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_MLO  = 4'd8;
    localparam logic [3:0] S_MHI  = 4'd9;
    localparam logic [3:0] S_FDS  = 4'd10;
    localparam logic [3:0] S_FDW  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    // ---------------------------------------------------------------- registers
    logic [3:0]           state_reg, state_next;
    logic [5:0]           interval_reg;
    logic [15:0]          scale_reg;
    logic [AW-1:0]        wp_reg;
    logic [CW-1:0]        fill_reg;
    logic [CW-1:0]        len_reg;
    logic [CW-1:0]        held_reg;
    logic [AW-1:0]        base_reg;
    logic [AW-1:0]        k_reg;
    logic                 ok_reg;
    logic [15:0]          new_x_reg, new_y_reg;
    logic                 have_prev_reg;
    logic signed [15:0]   prev_x_reg, prev_y_reg;
    logic [AW-1:0]        prev_k_reg;
    logic signed [16:0]   dx_reg, dy_reg;
    logic [AW-1:0]        g_reg;
    logic [31:0]          sqx_reg, sqy_reg;
    logic [LGW-1:0]       lg_reg;
    logic signed [PW-1:0] kdx_reg, kdy_reg;
    logic signed [SW-1:0] sum_x_reg, sum_y_reg;
    logic [WW-1:0]        weight_reg;
    logic                 axis_reg;
    logic                 neg_reg;
    logic [SMW-1:0]       mag_reg;
    logic [H+15:0]        plo_reg;
    logic [PRW-1:0]       prod_reg;
    logic [23:0]          spd_x_reg, spd_y_reg;
    logic                 m_tvalid_reg;
    logic                 pos_ok_reg;
    logic [15:0]          out_x_reg, out_y_reg;
    logic [23:0]          out_sx_reg, out_sy_reg;

    // ---------------------------------------------------------------- input side
    logic              accept;
    logic              in_valid;
    logic [15:0]       in_x, in_y;
    logic [LW-1:0]     iv_ext;
    logic [CW-1:0]     len_c;
    logic [CW-1:0]     fill_inc;
    logic [CW-1:0]     held_c;
    logic [AW-1:0]     wp_inc;
    logic [CW:0]       base_sum;
    logic [AW-1:0]     base_c;
    logic              ok_c;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_valid = s_tuser[0];
    assign in_x     = s_tdata[15:0];
    assign in_y     = s_tdata[31:16];

    // Clamp interval to 1..MAX_WINDOW, advance pointers, find the window base
    always_comb
    begin
        iv_ext = LW'(interval_reg);
        if (iv_ext == '0)
        begin
            len_c = CW'(1);
        end
        else if (iv_ext > LW'(MAX_WINDOW))
        begin
            len_c = CW'(MAX_WINDOW);
        end
        else
        begin
            len_c = iv_ext[CW-1:0];
        end

        fill_inc = (fill_reg == CW'(MAX_WINDOW)) ? fill_reg : fill_reg + CW'(1);
        held_c   = (fill_inc < len_c) ? fill_inc : len_c;
        wp_inc   = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + AW'(1);

        base_sum = (CW + 1)'(wp_inc) + (CW + 1)'(MAX_WINDOW) - (CW + 1)'(held_c);
        if (base_sum >= (CW + 1)'(MAX_WINDOW))
        begin
            base_sum = base_sum - (CW + 1)'(MAX_WINDOW);
        end
        base_c = base_sum[AW-1:0];
        ok_c   = (held_c > CW'(1)) && in_valid;
    end

    // ---------------------------------------------------------------- window RAM
    logic [AW:0]   rd_sum;
    logic [AW-1:0] rd_addr;
    logic [32:0]   rd_data;
    logic          e_valid;
    logic signed [15:0] e_x, e_y;

    always_comb
    begin
        rd_sum = (AW + 1)'(base_reg) + (AW + 1)'(k_reg);
        if (rd_sum >= (AW + 1)'(MAX_WINDOW))
        begin
            rd_sum = rd_sum - (AW + 1)'(MAX_WINDOW);
        end
        rd_addr = rd_sum[AW-1:0];
    end

    gve_ram #(
        .WIDTH (33),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata ({in_valid, in_x, in_y}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign e_valid = rd_data[32];
    assign e_x     = $signed(rd_data[31:16]);
    assign e_y     = $signed(rd_data[15:0]);

    // ---------------------------------------------------------------- pair math
    logic              last_k;
    logic signed [33:0] sqx_full, sqy_full;
    logic signed [AW+17:0] kdx_full, kdy_full;
    logic [CMPW-1:0]   d2;
    logic [CMPW-1:0]   lim2;
    logic              pass;
    logic [PW-1:0]     kdx_mag, kdy_mag;

    assign last_k   = ((CW'(k_reg) + CW'(1)) == held_reg);
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;
    assign kdx_full = $signed({1'b0, k_reg}) * dx_reg;
    assign kdy_full = $signed({1'b0, k_reg}) * dy_reg;
    assign d2       = CMPW'(({1'b0, sqx_reg} + {1'b0, sqy_reg}) * 38'(GATE_NUM));
    assign lim2     = CMPW'(lg_reg * lg_reg) << LIM_SHIFT;
    assign pass     = (d2 < lim2);
    assign kdx_mag  = kdx_reg[PW-1] ? PW'(-kdx_reg) : PW'(kdx_reg);
    assign kdy_mag  = kdy_reg[PW-1] ? PW'(-kdy_reg) : PW'(kdy_reg);

    // ---------------------------------------------------------------- shared divider
    logic          div_start;
    logic [DN-1:0] div_dividend;
    logic [DD-1:0] div_divisor;
    logic [DN-1:0] div_q;
    div_status_t   div_stat;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DN'({kdx_mag, 16'h0000});
        div_divisor  = DD'(g_reg);
        case (state_reg)
            S_GATE:
            begin
                div_start = pass;
            end
            S_DX:
            begin
                div_start    = div_stat.done;
                div_dividend = DN'({kdy_mag, 16'h0000});
            end
            S_FDS:
            begin
                div_start    = 1'b1;
                div_dividend = DN'(prod_reg[PRW-1:24]);
                div_divisor  = weight_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    gve_div #(
        .DN (DN),
        .DD (DD)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .status   (div_stat)
    );

    logic signed [SW-1:0] term;
    logic [HI+15:0]       phi;
    logic [DN-1:0]        q_clamp;
    logic [23:0]          spd_c;
    logic                 out_free;

    assign term     = $signed(SW'(div_q));
    assign phi      = mag_reg[SMW-1:H] * scale_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Clamp the scaled magnitude and restore the sign
    always_comb
    begin
        q_clamp = (div_q > DN'(SPD_MAG_LIM)) ? DN'(SPD_MAG_LIM) : div_q;
        if (neg_reg)
        begin
            spd_c = 24'(-q_clamp[23:0]);
            if (q_clamp == DN'(SPD_MAG_LIM))
            begin
                spd_c = SPD_MIN;
            end
        end
        else
        begin
            spd_c = (q_clamp >= DN'(SPD_MAG_LIM)) ? SPD_MAX : q_clamp[23:0];
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ok_c ? S_RD : S_OUT;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (e_valid && have_prev_reg)
                begin
                    state_next = S_SQ;
                end
                else
                begin
                    state_next = last_k ? S_FIN : S_RD;
                end
            end
            S_SQ:
            begin
                state_next = S_GATE;
            end
            S_GATE:
            begin
                if (pass)
                begin
                    state_next = S_DX;
                end
                else
                begin
                    state_next = last_k ? S_FIN : S_RD;
                end
            end
            S_DX:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DY;
                end
            end
            S_DY:
            begin
                if (div_stat.done)
                begin
                    state_next = last_k ? S_FIN : S_RD;
                end
            end
            S_FIN:
            begin
                state_next = (weight_reg == '0) ? S_OUT : S_MLO;
            end
            S_MLO:
            begin
                state_next = S_MHI;
            end
            S_MHI:
            begin
                state_next = S_FDS;
            end
            S_FDS:
            begin
                state_next = S_FDW;
            end
            S_FDW:
            begin
                if (div_stat.done)
                begin
                    state_next = axis_reg ? S_OUT : S_MLO;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            interval_reg  <= INTERVAL_RST;
            scale_reg     <= SCALE_RST;
            wp_reg        <= '0;
            fill_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            axis_reg      <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (psel && penable && pwrite)
            begin
                if (paddr[2] == REG_INTERVAL)
                begin
                    interval_reg <= pwdata[5:0];
                end
                else
                begin
                    scale_reg <= pwdata[15:0];
                end
            end

            if (accept)
            begin
                wp_reg        <= wp_inc;
                fill_reg      <= fill_inc;
                have_prev_reg <= 1'b0;
                axis_reg      <= 1'b0;
                k_reg         <= '0;
            end

            // Step to the next window entry
            if ((state_reg == S_CHK && !(e_valid && have_prev_reg)) ||
                (state_reg == S_GATE && !pass) ||
                (state_reg == S_DY && div_stat.done))
            begin
                k_reg <= k_reg + AW'(1);
            end

            if (state_reg == S_CHK && e_valid)
            begin
                have_prev_reg <= 1'b1;
            end

            if (state_reg == S_FDW && div_stat.done)
            begin
                axis_reg <= 1'b1;
            end

            if (state_reg == S_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg    <= len_c;
            held_reg   <= held_c;
            base_reg   <= base_c;
            ok_reg     <= ok_c;
            new_x_reg  <= in_x;
            new_y_reg  <= in_y;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            weight_reg <= '0;
            spd_x_reg  <= '0;
            spd_y_reg  <= '0;
        end

        case (state_reg)
            S_CHK:
            begin
                // Hold the difference to the previous valid sample, then move on
                if (e_valid)
                begin
                    dx_reg     <= 17'(e_x) - 17'(prev_x_reg);
                    dy_reg     <= 17'(e_y) - 17'(prev_y_reg);
                    g_reg      <= k_reg - prev_k_reg;
                    prev_x_reg <= e_x;
                    prev_y_reg <= e_y;
                    prev_k_reg <= k_reg;
                end
            end
            S_SQ:
            begin
                sqx_reg <= sqx_full[31:0];
                sqy_reg <= sqy_full[31:0];
                lg_reg  <= LGW'(len_reg * g_reg);
                kdx_reg <= kdx_full[PW-1:0];
            end
            S_GATE:
            begin
                kdy_reg <= kdy_full[PW-1:0];
            end
            S_DX:
            begin
                if (div_stat.done)
                begin
                    sum_x_reg <= kdx_reg[PW-1] ? sum_x_reg - term : sum_x_reg + term;
                end
            end
            S_DY:
            begin
                if (div_stat.done)
                begin
                    sum_y_reg  <= kdy_reg[PW-1] ? sum_y_reg - term : sum_y_reg + term;
                    weight_reg <= weight_reg + WW'(k_reg);
                end
            end
            S_FIN:
            begin
                neg_reg <= sum_x_reg[SW-1];
                mag_reg <= sum_x_reg[SW-1] ? SMW'(-sum_x_reg) : SMW'(sum_x_reg);
            end
            S_MLO:
            begin
                plo_reg <= mag_reg[H-1:0] * scale_reg;
            end
            S_MHI:
            begin
                prod_reg <= PRW'(plo_reg) + (PRW'(phi) << H);
            end
            S_FDW:
            begin
                if (div_stat.done)
                begin
                    if (axis_reg)
                    begin
                        spd_y_reg <= spd_c;
                    end
                    else
                    begin
                        spd_x_reg <= spd_c;
                        neg_reg   <= sum_y_reg[SW-1];
                        mag_reg   <= sum_y_reg[SW-1] ? SMW'(-sum_y_reg) : SMW'(sum_y_reg);
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    pos_ok_reg <= ok_reg;
                    out_x_reg  <= ok_reg ? new_x_reg : POS_INVALID;
                    out_y_reg  <= ok_reg ? new_y_reg : POS_INVALID;
                    out_sx_reg <= ok_reg ? spd_x_reg : '0;
                    out_sy_reg <= ok_reg ? spd_y_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------- ports
    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser[0] = pos_ok_reg;
    assign m_tdata    = {out_sy_reg, out_sx_reg, out_y_reg, out_x_reg};
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_SCALE) ? {16'h0000, scale_reg}
                                                : {26'h0, interval_reg};

    // ---------------------------------------------------------------- checks
    `GVE_ASSERT(a_fill_bound, fill_reg <= CW'(MAX_WINDOW), "fill count beyond window depth")
    `GVE_IMPLY(a_walk_index, state_reg == S_RD, CW'(k_reg) < held_reg, "walk past held samples")
    `GVE_IMPLY(a_div_idle, div_start, !div_stat.busy, "divider started while busy")
    `GVE_IMPLY(a_bad_pos, m_tvalid && !m_tuser[0], (m_tdata[15:0] == POS_INVALID) && (m_tdata[79:32] == '0), "invalid position with non-default fields")
    `GVE_NEXT(a_busy_after, accept, !s_tready, "second item taken during work")

endmodule

`default_nettype wire
